/* rtl/temperature_trend_detector_defines.svh */
// Assertion macros for the checker file of the trend detector.
`ifndef TEMPERATURE_TREND_DETECTOR_DEFINES_SVH
`define TEMPERATURE_TREND_DETECTOR_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define TTD_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trend detector assertion failed");

// Concurrent assertion that also holds while reset is asserted.
`define TTD_ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("trend detector assertion failed");

`endif

/* rtl/ttd_pkg.sv */
package ttd_pkg;

    localparam int TEMP_W   = 14;
    localparam int COUNT_W  = 8;
    localparam int THR_W    = 10;
    localparam int LIMIT_W  = 8;
    localparam int FACTOR_W = 7;

    // Signed numerator of the average; the weighted sum always fits here.
    localparam int NUM_W = TEMP_W + FACTOR_W;

    localparam int IN_DATA_W  = ((TEMP_W + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 * TEMP_W + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int TREND_LSB  = TEMP_W;
    localparam int DEV_LSB    = TEMP_W + 2;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_RISE_LIM  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DROP_LIM  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STAB_LIM  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FACTOR    = 3'd4;

    localparam logic [1:0] TREND_STABLE = 2'd0;
    localparam logic [1:0] TREND_RISE   = 2'd1;
    localparam logic [1:0] TREND_DROP   = 2'd2;

    typedef struct packed {
        logic start;
    } ema_ctl_t;

    typedef struct packed {
        logic done;
    } ema_stat_t;

endpackage

/* rtl/ttd_ema.sv */
module ttd_ema
    import ttd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ema_ctl_t                 ctl,
    input  logic signed [TEMP_W-1:0] avg_in,
    input  logic signed [TEMP_W-1:0] sample,
    input  logic [FACTOR_W-1:0]      factor,
    output ema_stat_t                stat,
    output logic signed [TEMP_W-1:0] avg_out
);

    // Serial multiply by (factor - 1), one multiplier bit per cycle, then a
    // restoring divide of the magnitude, one quotient bit per cycle.
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_MUL  = 5'b00010,
        E_ABS  = 5'b00100,
        E_DIV  = 5'b01000,
        E_NEG  = 5'b10000
    } ema_state_t;

    ema_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     done_reg;

    logic signed [NUM_W-1:0]  acc_reg;
    logic signed [NUM_W-1:0]  mcand_reg;
    logic [FACTOR_W-1:0]      mult_reg;
    logic [FACTOR_W-1:0]      div_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [FACTOR_W-1:0]      rem_reg;
    logic                     neg_reg;
    logic signed [TEMP_W-1:0] avg_reg;

    logic [FACTOR_W:0]        trial;
    logic                     fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = E_MUL;
                    count_next = CNT_W'(FACTOR_W - 1);
                end
            end
            E_MUL:
            begin
                if (count_reg == '0)
                begin
                    state_next = E_ABS;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            E_ABS:
            begin
                state_next = E_DIV;
                count_next = CNT_W'(NUM_W - 1);
            end
            E_DIV:
            begin
                if (count_reg == '0)
                begin
                    state_next = E_NEG;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            E_NEG:
            begin
                state_next = E_IDLE;
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == E_NEG);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            E_IDLE:
            begin
                if (ctl.start)
                begin
                    acc_reg   <= NUM_W'(sample);
                    mcand_reg <= NUM_W'(avg_in);
                    mult_reg  <= factor - 1'b1;
                    div_reg   <= factor;
                    rem_reg   <= '0;
                end
            end
            E_MUL:
            begin
                if (mult_reg[0])
                begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg <= mcand_reg <<< 1;
                mult_reg  <= mult_reg >> 1;
            end
            E_ABS:
            begin
                neg_reg <= acc_reg[NUM_W-1];
                num_reg <= acc_reg[NUM_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg);
            end
            E_DIV:
            begin
                if (fits)
                begin
                    rem_reg <= FACTOR_W'(trial - {1'b0, div_reg});
                end
                else
                begin
                    rem_reg <= trial[FACTOR_W-1:0];
                end
                num_reg <= {num_reg[NUM_W-2:0], fits};
            end
            E_NEG:
            begin
                avg_reg <= neg_reg ? -signed'(num_reg[TEMP_W-1:0])
                                   : signed'(num_reg[TEMP_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign stat.done = done_reg;
    assign avg_out   = avg_reg;

endmodule

/* rtl/temperature_trend_detector.sv */
// Channel   Dir  Handshake        Contents
// s_*       in   tvalid/tready    one temperature sample word
// m_*       out  tvalid/tready    smoothed value, trend and deviation word
// APB       in   psel/penable     five configuration registers, pready tied high
//
// The first sample after reset goes from acceptance straight to the trend
// step. Every later sample passes the serial multiply, the restoring divide,
// sign handling, the hand-off and the trend step; the next sample can be taken
// at the earliest edge at which the finished result word can itself be taken.
// A new sample is taken only while the block is idle; a finished word may
// still wait in the output register. Reset clears the average, reference,
// counters and trend and loads the register defaults.
module temperature_trend_detector
    import ttd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Sample input. s_tdata fields from bit 0: sample (14 bits, signed).
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,

    // Result output. m_tdata fields from bit 0: smoothed_temp (14 bits,
    // signed), trend (2 bits), deviation (14 bits, unsigned).
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CMP_W = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
    localparam logic [COUNT_W-1:0] CMAX = '1;

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_EMA   = 3'b010,
        T_TREND = 3'b100
    } top_state_t;

    // Configuration registers.
    logic [THR_W-1:0]    thr_reg;
    logic [LIMIT_W-1:0]  rise_lim_reg;
    logic [LIMIT_W-1:0]  drop_lim_reg;
    logic [LIMIT_W-1:0]  stab_lim_reg;
    logic [FACTOR_W-1:0] factor_reg;

    // Tracking state.
    top_state_t               state_reg;
    logic signed [TEMP_W-1:0] avg_reg;
    logic signed [TEMP_W-1:0] ref_reg;
    logic                     have_reg;
    logic [1:0]               trend_reg;
    logic [COUNT_W-1:0]       rise_cnt_reg;
    logic [COUNT_W-1:0]       drop_cnt_reg;
    logic [COUNT_W-1:0]       stab_cnt_reg;

    // Output word register.
    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] out_avg_reg;
    logic [1:0]               out_trend_reg;
    logic [TEMP_W-1:0]        out_dev_reg;

    logic                     s_accept;
    logic                     cfg_write;
    logic [IDX_W-1:0]         cfg_idx;
    logic                     out_free;
    logic                     do_trend;

    ema_ctl_t                 ema_ctl;
    ema_stat_t                ema_stat;
    logic signed [TEMP_W-1:0] ema_avg;
    logic [FACTOR_W-1:0]      factor_eff;

    logic signed [TEMP_W:0]   diff;
    logic signed [TEMP_W:0]   thr_ext;
    logic                     is_rise;
    logic                     is_drop;
    logic [TEMP_W-1:0]        dev;
    logic [COUNT_W-1:0]       rise_bump;
    logic [COUNT_W-1:0]       drop_bump;
    logic [COUNT_W-1:0]       stab_bump;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == CMAX) ? c : c + 1'b1;
    endfunction

    assign s_tready  = (state_reg == T_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign do_trend  = (state_reg == T_TREND) && out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W-1:2];

    // A zero factor behaves as a factor of one, which passes the sample through.
    assign factor_eff    = (factor_reg == '0) ? FACTOR_W'(1) : factor_reg;
    assign ema_ctl.start = s_accept && have_reg;

    ttd_ema u_ema (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ema_ctl),
        .avg_in  (avg_reg),
        .sample  (signed'(s_tdata[TEMP_W-1:0])),
        .factor  (factor_eff),
        .stat    (ema_stat),
        .avg_out (ema_avg)
    );

    // Deviation from the reference and the rise and drop tests.
    assign diff    = (TEMP_W + 1)'(avg_reg) - (TEMP_W + 1)'(ref_reg);
    assign thr_ext = signed'({{(TEMP_W + 1 - THR_W){1'b0}}, thr_reg});
    assign is_rise = (diff > thr_ext);
    assign is_drop = (diff < -thr_ext);
    assign dev     = diff[TEMP_W] ? TEMP_W'(-diff) : diff[TEMP_W-1:0];

    assign rise_bump = bump(rise_cnt_reg);
    assign drop_bump = bump(drop_cnt_reg);
    assign stab_bump = bump(stab_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THR_W'(10);
            rise_lim_reg <= LIMIT_W'(3);
            drop_lim_reg <= LIMIT_W'(3);
            stab_lim_reg <= LIMIT_W'(5);
            factor_reg   <= FACTOR_W'(4);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_THRESHOLD: thr_reg      <= pwdata[THR_W-1:0];
                REG_RISE_LIM:  rise_lim_reg <= pwdata[LIMIT_W-1:0];
                REG_DROP_LIM:  drop_lim_reg <= pwdata[LIMIT_W-1:0];
                REG_STAB_LIM:  stab_lim_reg <= pwdata[LIMIT_W-1:0];
                REG_FACTOR:    factor_reg   <= pwdata[FACTOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_THRESHOLD: prdata = 32'(thr_reg);
            REG_RISE_LIM:  prdata = 32'(rise_lim_reg);
            REG_DROP_LIM:  prdata = 32'(drop_lim_reg);
            REG_STAB_LIM:  prdata = 32'(stab_lim_reg);
            REG_FACTOR:    prdata = 32'(factor_reg);
            default:       prdata = '0;
        endcase
    end

    // Sequencing, averaging state and the trend counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            avg_reg      <= '0;
            ref_reg      <= '0;
            have_reg     <= 1'b0;
            trend_reg    <= TREND_STABLE;
            rise_cnt_reg <= '0;
            drop_cnt_reg <= '0;
            stab_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                T_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (have_reg)
                        begin
                            state_reg <= T_EMA;
                        end
                        else
                        begin
                            // The first sample seeds both the average and the
                            // reference level.
                            avg_reg   <= signed'(s_tdata[TEMP_W-1:0]);
                            ref_reg   <= signed'(s_tdata[TEMP_W-1:0]);
                            have_reg  <= 1'b1;
                            state_reg <= T_TREND;
                        end
                    end
                end
                T_EMA:
                begin
                    if (ema_stat.done)
                    begin
                        avg_reg   <= ema_avg;
                        state_reg <= T_TREND;
                    end
                end
                T_TREND:
                begin
                    if (out_free)
                    begin
                        state_reg <= T_IDLE;
                        if (is_rise)
                        begin
                            if (CMP_W'(rise_bump) >= CMP_W'(rise_lim_reg))
                            begin
                                ref_reg      <= avg_reg;
                                trend_reg    <= TREND_RISE;
                                rise_cnt_reg <= '0;
                                drop_cnt_reg <= '0;
                                stab_cnt_reg <= '0;
                            end
                            else
                            begin
                                rise_cnt_reg <= rise_bump;
                            end
                        end
                        else if (is_drop)
                        begin
                            if (CMP_W'(drop_bump) >= CMP_W'(drop_lim_reg))
                            begin
                                ref_reg      <= avg_reg;
                                trend_reg    <= TREND_DROP;
                                rise_cnt_reg <= '0;
                                drop_cnt_reg <= '0;
                                stab_cnt_reg <= '0;
                            end
                            else
                            begin
                                drop_cnt_reg <= drop_bump;
                            end
                        end
                        else
                        begin
                            if (CMP_W'(stab_bump) >= CMP_W'(stab_lim_reg))
                            begin
                                // On a settle, the reference only moves when
                                // leaving a rising or dropping trend.
                                if (trend_reg != TREND_STABLE)
                                begin
                                    ref_reg <= avg_reg;
                                end
                                trend_reg    <= TREND_STABLE;
                                rise_cnt_reg <= '0;
                                drop_cnt_reg <= '0;
                                stab_cnt_reg <= '0;
                            end
                            else
                            begin
                                stab_cnt_reg <= stab_bump;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // The output word carries the trend as it stands after this sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_trend)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_trend)
        begin
            out_avg_reg <= avg_reg;
            out_dev_reg <= dev;
            if (is_rise)
            begin
                out_trend_reg <= (CMP_W'(rise_bump) >= CMP_W'(rise_lim_reg))
                               ? TREND_RISE : trend_reg;
            end
            else if (is_drop)
            begin
                out_trend_reg <= (CMP_W'(drop_bump) >= CMP_W'(drop_lim_reg))
                               ? TREND_DROP : trend_reg;
            end
            else
            begin
                out_trend_reg <= (CMP_W'(stab_bump) >= CMP_W'(stab_lim_reg))
                               ? TREND_STABLE : trend_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_dev_reg, out_trend_reg,
                       out_avg_reg};

endmodule

/* rtl/ttd_checker.sv */
`include "temperature_trend_detector_defines.svh"

module ttd_checker
    import ttd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  pready
);

    logic [1:0] trend_out;
    logic       trend_ok;

    assign trend_out = m_tdata[TREND_LSB+1:TREND_LSB];
    assign trend_ok  = (trend_out == TREND_STABLE) || (trend_out == TREND_RISE)
                    || (trend_out == TREND_DROP);

    // One sample at a time: the input closes right after a word is taken.
    `TTD_ASSERT_RST(a_one_in_flight, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)

    // A waiting result word stays offered until it is taken.
    `TTD_ASSERT_RST(a_out_held, clk, rst_n, (m_tvalid && !m_tready) |=> m_tvalid)

    // The trend field only ever carries one of its three codes.
    `TTD_ASSERT_RST(a_trend_code, clk, rst_n, m_tvalid |-> trend_ok)

    // Once reset is seen low, no result is offered and pready is high.
    `TTD_ASSERT_CLK(a_reset_quiet, clk, !rst_n |=> (!m_tvalid && pready))

endmodule

bind temperature_trend_detector ttd_checker u_ttd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ttd_pkg::*;

    // A run ends early when this many cycles pass with no transfer on any port.
    // It must stay well above the long receiver stall below.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 400;
    localparam int DRAIN_CYCLES   = 40;

    // Register indexes that the block does not decode. Writes to them must not
    // disturb any setting.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Directed opening samples, applied with the reset settings. The first one
    // loads the average and the reference; the rest walk through a settle, a
    // rise, a drop and the corners of the 14-bit sample field.
    localparam int DIRECTED [24] = '{
        -4000, -4000, -4000, -4000, -4000,
        8191, 8191, 8191, 8191, 8191, 8191,
        -8192, -8192, -8192, -8192, -8192, -8192,
        8000, -4000, 0, -1, 1, 8191, -8192
    };

    // One result word, split into its fields.
    typedef struct {
        logic signed [TEMP_W-1:0] smooth;
        logic [1:0]               trend;
        logic [TEMP_W-1:0]        dev;
    } trend_word_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    temperature_trend_detector u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the register file, updated when a write is seen on the
    // configuration port.
    logic [THR_W-1:0]    cfg_thr      = THR_W'(10);
    logic [LIMIT_W-1:0]  cfg_rise_lim = LIMIT_W'(3);
    logic [LIMIT_W-1:0]  cfg_drop_lim = LIMIT_W'(3);
    logic [LIMIT_W-1:0]  cfg_stab_lim = LIMIT_W'(5);
    logic [FACTOR_W-1:0] cfg_factor   = FACTOR_W'(4);

    // Model state of the detector, as it stands after reset.
    int                  avg_model   = 0;
    int                  ref_model   = 0;
    bit                  have_model  = 1'b0;
    logic [1:0]          trend_model = TREND_STABLE;
    logic [COUNT_W-1:0]  rise_cnt    = '0;
    logic [COUNT_W-1:0]  drop_cnt    = '0;
    logic [COUNT_W-1:0]  stab_cnt    = '0;

    logic [TEMP_W-1:0]   sample_queue[$];
    trend_word_t         predicted_words[$];

    // Handshake flags taken at the rising edge and used by the drivers at the
    // following falling edge.
    bit s_fire = 1'b0;
    bit m_fire = 1'b0;

    int s_gap_left     = 0;
    int s_burst_left   = 0;
    int m_gap_left     = 0;
    int m_burst_left   = 0;
    int stall_left     = 0;
    bit long_stall_req = 1'b0;

    int error_count       = 0;
    int words_outstanding = 0;
    int samples_sent      = 0;
    int words_checked     = 0;
    int settings_used     = 1;
    int rises_seen        = 0;
    int drops_seen        = 0;
    int settles_seen      = 0;
    int quiet_cycles      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("%0t ERROR %s", $time, msg);
        error_count++;
    endtask

    // Wait per word: mostly a value from 0 to 13, with occasional runs of words that
    // follow each other back to back.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Advances the model by one sample and returns the word the block should
    // emit for it. The deviation is taken against the reference as it stood
    // before this sample's trend decision.
    function automatic trend_word_t step_trend_model(input logic [TEMP_W-1:0] raw);
        trend_word_t w;
        int          s;
        int          f;
        int          diff;
        int          mag;
        s = $signed(raw);
        f = (cfg_factor == 0) ? 1 : int'(cfg_factor);
        if (!have_model)
        begin
            avg_model  = s;
            ref_model  = s;
            have_model = 1'b1;
        end
        else
        begin
            // Integer division in SystemVerilog truncates toward zero.
            avg_model = (avg_model * (f - 1) + s) / f;
        end
        diff = avg_model - ref_model;
        mag  = (diff < 0) ? -diff : diff;

        if (diff > int'(cfg_thr))
        begin
            rise_cnt = (rise_cnt == '1) ? rise_cnt : rise_cnt + 1'b1;
            if (rise_cnt >= cfg_rise_lim)
            begin
                ref_model   = avg_model;
                rise_cnt    = '0;
                drop_cnt    = '0;
                stab_cnt    = '0;
                trend_model = TREND_RISE;
                rises_seen++;
            end
        end
        else if (-diff > int'(cfg_thr))
        begin
            drop_cnt = (drop_cnt == '1) ? drop_cnt : drop_cnt + 1'b1;
            if (drop_cnt >= cfg_drop_lim)
            begin
                ref_model   = avg_model;
                rise_cnt    = '0;
                drop_cnt    = '0;
                stab_cnt    = '0;
                trend_model = TREND_DROP;
                drops_seen++;
            end
        end
        else
        begin
            stab_cnt = (stab_cnt == '1) ? stab_cnt : stab_cnt + 1'b1;
            if (stab_cnt >= cfg_stab_lim)
            begin
                // Settling after a rise or drop moves the reference; a settle
                // while already stable leaves it where it is.
                if (trend_model != TREND_STABLE)
                    ref_model = avg_model;
                rise_cnt    = '0;
                drop_cnt    = '0;
                stab_cnt    = '0;
                trend_model = TREND_STABLE;
                settles_seen++;
            end
        end

        w.smooth = avg_model[TEMP_W-1:0];
        w.trend  = trend_model;
        w.dev    = mag[TEMP_W-1:0];
        return w;
    endfunction

    // Rising-edge monitor: predicts on every accepted sample, checks every
    // accepted result word against the oldest prediction, and follows
    // register writes into the shadow copy.
    always @(posedge clk)
    begin
        s_fire = rst_n && s_tvalid && s_tready;
        m_fire = rst_n && m_tvalid && m_tready;

        if (rst_n && psel && penable && pwrite && pready)
        begin
            case (paddr[ADDR_W-1:2])
                REG_THRESHOLD: cfg_thr      = pwdata[THR_W-1:0];
                REG_RISE_LIM:  cfg_rise_lim = pwdata[LIMIT_W-1:0];
                REG_DROP_LIM:  cfg_drop_lim = pwdata[LIMIT_W-1:0];
                REG_STAB_LIM:  cfg_stab_lim = pwdata[LIMIT_W-1:0];
                REG_FACTOR:    cfg_factor   = pwdata[FACTOR_W-1:0];
                default: ;
            endcase
        end

        if (s_fire)
            predicted_words.push_back(step_trend_model(s_tdata[TEMP_W-1:0]));

        if (m_fire)
        begin
            words_checked++;
            words_outstanding--;
            if (predicted_words.size() == 0)
            begin
                report_error($sformatf("result word 0x%0h arrived with none pending", m_tdata));
            end
            else
            begin
                trend_word_t want;
                want = predicted_words.pop_front();
                if (m_tdata[TEMP_W-1:0] !== want.smooth)
                    report_error($sformatf("word %0d smoothed_temp got %0d want %0d",
                        words_checked, $signed(m_tdata[TEMP_W-1:0]), want.smooth));
                if (m_tdata[TREND_LSB +: 2] !== want.trend)
                    report_error($sformatf("word %0d trend got %0d want %0d",
                        words_checked, m_tdata[TREND_LSB +: 2], want.trend));
                if (m_tdata[DEV_LSB +: TEMP_W] !== want.dev)
                    report_error($sformatf("word %0d deviation got %0d want %0d",
                        words_checked, m_tdata[DEV_LSB +: TEMP_W], want.dev));
            end
        end
    end

    // Sample driver. A word stays on the bus until it is taken; after that the
    // driver idles for the drawn number of cycles before offering the next.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_fire)
        begin
            if (s_gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                s_gap_left--;
            end
            else if (sample_queue.size() > 0)
            begin
                s_tdata    <= {{(IN_DATA_W - TEMP_W){1'b0}}, sample_queue.pop_front()};
                s_tvalid   <= 1'b1;
                s_gap_left = draw_gap(s_burst_left);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver. After each word it stalls for a drawn number of cycles;
    // on request it holds off for one long stretch so that the block backs up
    // and refuses samples while the driver keeps offering them.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_fire)
                m_gap_left = draw_gap(m_burst_left);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left     = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (m_gap_left > 0)
            begin
                m_tready <= 1'b0;
                m_gap_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: any transfer on the stream ports or a register write counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer, %0d words outstanding",
                quiet_cycles, words_outstanding);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Register write: setup, then access. The register takes the
    // value at the rising edge inside the access cycle.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_settings(input int thr, input int rise_lim, input int drop_lim,
                                  input int stab_lim, input int factor);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_RISE_LIM, rise_lim);
        write_reg(REG_DROP_LIM, drop_lim);
        write_reg(REG_STAB_LIM, stab_lim);
        write_reg(REG_FACTOR, factor);
        settings_used++;
    endtask

    task automatic queue_sample(input logic [TEMP_W-1:0] value);
        sample_queue.push_back(value);
        words_outstanding++;
        samples_sent++;
    endtask

    // Temperature-like stimulus: ramps up, ramps down and plateaus with a
    // little jitter, so the counters actually reach their limits. About one
    // sample in ten is a raw 14-bit pattern, which covers every input bit and
    // the values outside the sensor range.
    task automatic queue_walk(input int count, input int step_max);
        int level;
        int slope;
        int seg_left;
        level    = int'($urandom_range(0, 12000)) - 4000;
        slope    = 0;
        seg_left = 0;
        repeat (count)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(3, 25);
                case ($urandom_range(0, 2))
                    0:       slope = int'($urandom_range(1, step_max));
                    1:       slope = -int'($urandom_range(1, step_max));
                    default: slope = 0;
                endcase
            end
            seg_left--;
            level = level + slope + int'($urandom_range(0, 4)) - 2;
            if (level > 8000)
                level = 8000;
            if (level < -4000)
                level = -4000;
            if ($urandom_range(0, 9) == 0)
                queue_sample(TEMP_W'($urandom));
            else
                queue_sample(TEMP_W'(level));
        end
    endtask

    // Every queued sample has produced its checked result word; with one word
    // per sample the block is then idle and may be reconfigured.
    task automatic wait_drained();
        @(negedge clk);
        while (words_outstanding > 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, directed samples.
        foreach (DIRECTED[i])
            queue_sample(TEMP_W'(DIRECTED[i]));
        wait_drained();

        // Lowest settings: any change counts, every event fires at once and
        // the average follows the sample.
        write_settings(0, 1, 1, 1, 1);
        queue_walk(120, 20);
        wait_drained();

        // High settings: long, heavily smoothed runs that let the stable
        // counter climb all the way to its top value.
        write_settings(1000, 255, 255, 255, 64);
        queue_walk(300, 150);
        wait_drained();

        // A zero factor acts as one, and zero limits fire on every qualifying
        // sample.
        write_settings($urandom_range(0, 30), 0, 0, 0, 0);
        queue_walk(80, 60);
        wait_drained();

        // Upper register bits set (they must be dropped), a factor above 64,
        // and writes to undecoded indexes that must change nothing.
        write_settings(32'hFFFF_FC00 | $urandom_range(0, 50), 32'hABCD_EF02,
                       32'h5A5A_A503, 32'hFFFF_FF04, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        queue_walk(100, 80);
        wait_drained();

        // Back to the reset values, with one long receiver stall so that the
        // output word backs up and the input is refused for a while.
        write_settings(10, 3, 3, 5, 4);
        queue_walk(150, 40);
        @(posedge clk);
        long_stall_req = 1'b1;
        wait_drained();

        // Random settings, mostly small thresholds, limits and factors so that
        // trend changes stay frequent.
        repeat (4)
        begin
            write_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000)
                                                       : $urandom_range(0, 40),
                           $urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(1, 10), $urandom_range(1, 16));
            queue_walk(50, $urandom_range(5, 120));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Coverage: %0d samples under %0d register settings, %0d result words checked.",
            samples_sent, settings_used, words_checked);
        $display("Trend events predicted: %0d rise, %0d drop, %0d settle.",
            rises_seen, drops_seen, settles_seen);
        if (error_count == 0 && predicted_words.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            if (predicted_words.size() != 0)
                $display("%0d predicted words never arrived", predicted_words.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ttd_pkg.sv
rtl/ttd_ema.sv
rtl/temperature_trend_detector.sv
rtl/ttd_checker.sv
dv/testbench.sv
